### sv/msa_pkg.sv
// Package for the mesh surface area accumulator.
// Holds item types and fixed datapath widths; no dependencies.
package msa_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MUL_BITS   = DIFF_BITS + 1;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
   localparam int CMAG_BITS  = CROSS_BITS - 1;
   localparam int HALF_CMAG  = CMAG_BITS / 2;
   localparam int RAD_BITS   = 2 * CMAG_BITS;
   localparam int ROOT_BITS  = CMAG_BITS;
   localparam int LEN_BITS   = ROOT_BITS + 1;
   localparam int HALF_BITS  = ROOT_BITS + 2;
   localparam int AREA_BITS  = 50;
   localparam int TOTAL_BITS = 64;
   localparam int STEP_BITS  = 4;
   localparam int CROSS_STEPS = 6;
   localparam int LAST_STEP   = 14;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] a_z;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] b_z;
      logic signed [COORD_BITS-1:0] c_x;
      logic signed [COORD_BITS-1:0] c_y;
      logic signed [COORD_BITS-1:0] c_z;
      logic                         quad_first;
      logic                         last_in_mesh;
   } msa_req_type;

   typedef struct packed {
      logic [AREA_BITS-1:0]  polygon_area;
      logic [TOTAL_BITS-1:0] total_area;
      logic                  mesh_done;
   } msa_rsp_type;

endpackage

### sv/msa_mul.sv
// Shared signed multiplier with a registered product.
// Depends on msa_pkg for operand and product widths.
module msa_mul (
   input  logic                                clock,
   input  logic signed [msa_pkg::MUL_BITS-1:0]  op_a,
   input  logic signed [msa_pkg::MUL_BITS-1:0]  op_b,
   output logic signed [msa_pkg::PROD_BITS-1:0] prod
);
   import msa_pkg::*;

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### sv/msa_isqrt.sv
// Bit-serial floored integer square root, one root bit per cycle.
// Depends on msa_pkg for radicand and root widths.
module msa_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [msa_pkg::RAD_BITS-1:0]      radicand,
   output logic                              done,
   output logic [msa_pkg::ROOT_BITS-1:0]     root
);
   import msa_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int CNT_BITS = $clog2(ROOT_BITS);
   localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(ROOT_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [RAD_BITS-1:0]   rad_ff, rad_in;
   logic [REM_BITS+1:0]   rem_sh;
   logic [REM_BITS+1:0]   trial;
   logic [REM_BITS+1:0]   rem_sub;

   assign rem_sh  = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign rem_sub = rem_sh - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rad_in  = rad_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_TOP;
         rem_in  = '0;
         root_in = '0;
         rad_in  = radicand;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### sv/mesh_surface_area_accumulator.sv
// Mesh surface area accumulator: top level with sequencer and polygon totals.
// Depends on msa_pkg, msa_mul and msa_isqrt.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   msa_req_type, one triangle
//   rsp      out        rsp_valid/rsp_stall   msa_rsp_type, one polygon
//
// A triangle is handled in order: the item is taken, fifteen products go
// through the shared multiplier, the 50-iteration square root runs, and the
// result is finished.
// Reset is synchronous and clears the held quad half and the running total.
// A stalled result is held in the output register; a new item is taken
// meanwhile, and a finish that gives a result waits until the result leaves.
module mesh_surface_area_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  msa_pkg::msa_req_type  req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msa_pkg::msa_rsp_type  rsp_item
);
   import msa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SQS  = 3'd2;
   localparam logic [2:0] ST_SQW  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         phase_ff, phase_in;
   logic signed [DIFF_BITS-1:0]  u_ff [3];
   logic signed [DIFF_BITS-1:0]  v_ff [3];
   logic signed [DIFF_BITS-1:0]  u_in [3];
   logic signed [DIFF_BITS-1:0]  v_in [3];
   logic                         first_ff, first_in;
   logic                         last_ff, last_in;
   logic signed [CROSS_BITS-1:0] acc_ff, acc_in;
   logic [CMAG_BITS-1:0]         cmag_ff [3];
   logic [CMAG_BITS-1:0]         cmag_in [3];
   logic                         neg_ff, neg_in;
   logic [RAD_BITS-1:0]          rad_ff, rad_in;
   logic signed [HALF_BITS-1:0]  held_ff, held_in;
   logic                         pend_ff, pend_in;
   logic [TOTAL_BITS-1:0]        total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   msa_rsp_type                  rsp_ff, rsp_in;

   logic                         req_fire;
   logic [1:0]                   sel_u, sel_v, sq_k, sq_j;
   logic signed [MUL_BITS-1:0]   op_a, op_b;
   logic signed [PROD_BITS-1:0]  prod;
   logic signed [CROSS_BITS-1:0] diff;
   logic [CROSS_BITS-1:0]        diff_mag;
   logic [RAD_BITS-1:0]          sq_add;
   logic                         sqrt_done;
   logic [ROOT_BITS-1:0]         root;
   logic signed [LEN_BITS-1:0]   len;
   logic signed [HALF_BITS-1:0]  sum;
   logic [HALF_BITS-1:0]         sum_mag;
   logic [AREA_BITS-1:0]         area;
   logic [TOTAL_BITS:0]          tot_wide;
   logic [TOTAL_BITS-1:0]        tot;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // operand schedule: six cross products, then three partial squares each
   always_comb begin
      sel_u = 2'd0;
      sel_v = 2'd0;
      sq_k  = 2'd0;
      sq_j  = 2'd0;
      case (step_ff)
         4'd0:    begin sel_u = 2'd1; sel_v = 2'd2; end
         4'd1:    begin sel_u = 2'd2; sel_v = 2'd1; end
         4'd2:    begin sel_u = 2'd2; sel_v = 2'd0; end
         4'd3:    begin sel_u = 2'd0; sel_v = 2'd2; end
         4'd4:    begin sel_u = 2'd0; sel_v = 2'd1; end
         4'd5:    begin sel_u = 2'd1; sel_v = 2'd0; end
         4'd6:    begin sq_k = 2'd0; sq_j = 2'd0; end
         4'd7:    begin sq_k = 2'd0; sq_j = 2'd1; end
         4'd8:    begin sq_k = 2'd0; sq_j = 2'd2; end
         4'd9:    begin sq_k = 2'd1; sq_j = 2'd0; end
         4'd10:   begin sq_k = 2'd1; sq_j = 2'd1; end
         4'd11:   begin sq_k = 2'd1; sq_j = 2'd2; end
         4'd12:   begin sq_k = 2'd2; sq_j = 2'd0; end
         4'd13:   begin sq_k = 2'd2; sq_j = 2'd1; end
         4'd14:   begin sq_k = 2'd2; sq_j = 2'd2; end
         default: begin sq_k = 2'd0; sq_j = 2'd0; end
      endcase
   end

   always_comb begin
      if (step_ff < STEP_BITS'(CROSS_STEPS)) begin
         op_a = MUL_BITS'(u_ff[sel_u]);
         op_b = MUL_BITS'(v_ff[sel_v]);
      end else begin
         case (sq_j)
            2'd0: begin
               op_a = {1'b0, cmag_ff[sq_k][CMAG_BITS-1:HALF_CMAG]};
               op_b = {1'b0, cmag_ff[sq_k][CMAG_BITS-1:HALF_CMAG]};
            end
            2'd1: begin
               op_a = {1'b0, cmag_ff[sq_k][CMAG_BITS-1:HALF_CMAG]};
               op_b = {1'b0, cmag_ff[sq_k][HALF_CMAG-1:0]};
            end
            default: begin
               op_a = {1'b0, cmag_ff[sq_k][HALF_CMAG-1:0]};
               op_b = {1'b0, cmag_ff[sq_k][HALF_CMAG-1:0]};
            end
         endcase
      end
   end

   msa_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   msa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SQS),
      .radicand (rad_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   assign diff     = acc_ff - prod[CROSS_BITS-1:0];
   assign diff_mag = diff[CROSS_BITS-1] ? CROSS_BITS'(-diff) : CROSS_BITS'(diff);

   always_comb begin
      case (sq_j)
         2'd0:    sq_add = {prod[CMAG_BITS-1:0], {CMAG_BITS{1'b0}}};
         2'd1:    sq_add = RAD_BITS'({prod[CMAG_BITS-1:0], {(HALF_CMAG+1){1'b0}}});
         default: sq_add = RAD_BITS'(prod[CMAG_BITS-1:0]);
      endcase
   end

   assign len      = neg_ff ? -LEN_BITS'(root) : LEN_BITS'(root);
   assign sum      = (pend_ff ? held_ff : '0) + HALF_BITS'(len);
   assign sum_mag  = sum[HALF_BITS-1] ? HALF_BITS'(-sum) : HALF_BITS'(sum);
   assign area     = sum_mag[AREA_BITS:1];
   assign tot_wide = {1'b0, total_ff} + (TOTAL_BITS+1)'(area);
   assign tot      = tot_wide[TOTAL_BITS] ? '1 : tot_wide[TOTAL_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      cmag_in      = cmag_ff;
      neg_in       = neg_ff;
      rad_in       = rad_ff;
      held_in      = held_ff;
      pend_in      = pend_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               u_in[0]  = DIFF_BITS'(req_item.b_x) - DIFF_BITS'(req_item.a_x);
               u_in[1]  = DIFF_BITS'(req_item.b_y) - DIFF_BITS'(req_item.a_y);
               u_in[2]  = DIFF_BITS'(req_item.b_z) - DIFF_BITS'(req_item.a_z);
               v_in[0]  = DIFF_BITS'(req_item.c_x) - DIFF_BITS'(req_item.a_x);
               v_in[1]  = DIFF_BITS'(req_item.c_y) - DIFF_BITS'(req_item.a_y);
               v_in[2]  = DIFF_BITS'(req_item.c_z) - DIFF_BITS'(req_item.a_z);
               first_in = req_item.quad_first;
               last_in  = req_item.last_in_mesh;
               rad_in   = '0;
               step_in  = '0;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff < STEP_BITS'(CROSS_STEPS)) begin
                  if (!step_ff[0]) begin
                     acc_in = prod[CROSS_BITS-1:0];
                  end else begin
                     cmag_in[step_ff[2:1]] = diff_mag[CMAG_BITS-1:0];
                     if (step_ff == STEP_BITS'(CROSS_STEPS - 1)) begin
                        neg_in = diff[CROSS_BITS-1];
                     end
                  end
               end else begin
                  rad_in = rad_ff + sq_add;
               end
               if (step_ff == STEP_BITS'(LAST_STEP)) begin
                  state_in = ST_SQS;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_SQS: begin
            state_in = ST_SQW;
         end
         ST_SQW: begin
            if (sqrt_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!pend_ff && first_ff) begin
               held_in  = HALF_BITS'(len);
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_in.polygon_area = area;
               rsp_in.total_area   = tot;
               rsp_in.mesh_done    = last_ff;
               rsp_valid_in        = 1'b1;
               total_in            = last_ff ? '0 : tot;
               pend_in             = 1'b0;
               held_in             = '0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff  <= step_in;
      phase_ff <= phase_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      cmag_ff  <= cmag_in;
      neg_ff   <= neg_in;
      rad_ff   <= rad_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_root_in_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQW)
      else $error("square root finished outside its wait state");

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MUL && step_ff == '0 && !phase_ff)
      else $error("accepted item did not start the multiply sequence");

   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> held_ff == '0)
      else $error("held quad half not cleared while nothing pending");

   a_fin_nomul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQS |-> $past(state_ff) == ST_MUL && $past(step_ff) == LAST_STEP)
      else $error("root started before the last square was added");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for mesh_surface_area_accumulator: triangles and quads in,
// polygon areas and running mesh totals checked against an in-bench area predictor.
// Depends on msa_pkg and the accumulator RTL only.
module tb_top;
   import msa_pkg::*;

   localparam int COORD_MIN = -8388608;
   localparam int COORD_MAX = 8388607;
   localparam int ONE = 4096;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 300;
   localparam logic [51:0] LENGTH_MAX = (52'd1 << 50) - 52'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   msa_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   msa_rsp_type rsp_item;

   msa_rsp_type pending_polygons[$];
   logic signed [51:0] held_length = '0;
   logic quad_held = 1'b0;
   logic [63:0] mesh_total = '0;
   int mismatch_count = 0;
   int triangles_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   mesh_surface_area_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // signed length of the edge cross product, negative when its z part is
   function automatic logic signed [51:0] cross_length(msa_req_type t);
      logic signed [24:0] ux, uy, uz, vx, vy, vz;
      logic signed [51:0] nx, ny, nz;
      logic [51:0] mx, my, mz;
      logic [127:0] radicand, trial_sq;
      logic [49:0] root, trial;
      int bit_pos;
      ux = $signed(t.b_x) - $signed(t.a_x);
      uy = $signed(t.b_y) - $signed(t.a_y);
      uz = $signed(t.b_z) - $signed(t.a_z);
      vx = $signed(t.c_x) - $signed(t.a_x);
      vy = $signed(t.c_y) - $signed(t.a_y);
      vz = $signed(t.c_z) - $signed(t.a_z);
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      mx = (nx < 0) ? -nx : nx;
      my = (ny < 0) ? -ny : ny;
      mz = (nz < 0) ? -nz : nz;
      radicand = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
      root = '0;
      if (mx > LENGTH_MAX || my > LENGTH_MAX || mz > LENGTH_MAX ||
          radicand >= (128'd1 << 100)) begin
         root = '1;
      end else begin
         for (bit_pos = 49; bit_pos >= 0; bit_pos--) begin
            trial = root | (50'd1 << bit_pos);
            trial_sq = 128'(trial) * 128'(trial);
            if (trial_sq <= radicand) root = trial;
         end
      end
      return (nz < 0) ? -$signed({2'b00, root}) : $signed({2'b00, root});
   endfunction

   function automatic void predict_polygon(msa_req_type t);
      logic signed [51:0] len;
      logic signed [52:0] sum;
      logic [52:0] mag;
      logic [64:0] grown;
      msa_rsp_type poly;
      len = cross_length(t);
      if (!quad_held && t.quad_first) begin
         held_length = len;
         quad_held = 1'b1;
         return;
      end
      if (quad_held) begin
         sum = held_length + len;
         held_length = '0;
         quad_held = 1'b0;
      end else begin
         sum = len;
      end
      mag = (sum < 0) ? -sum : sum;
      poly.polygon_area = mag[50:1];
      grown = {1'b0, mesh_total} + 65'(poly.polygon_area);
      mesh_total = grown[64] ? '1 : grown[63:0];
      poly.total_area = mesh_total;
      poly.mesh_done = t.last_in_mesh;
      pending_polygons.push_back(poly);
      if (t.last_in_mesh) mesh_total = '0;
   endfunction

   function automatic msa_req_type make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                            input bit qf, lm);
      msa_req_type t;
      t.a_x = 24'(ax);
      t.a_y = 24'(ay);
      t.a_z = 24'(az);
      t.b_x = 24'(bx);
      t.b_y = 24'(by);
      t.b_z = 24'(bz);
      t.c_x = 24'(cx);
      t.c_y = 24'(cy);
      t.c_z = 24'(cz);
      t.quad_first = qf;
      t.last_in_mesh = lm;
      return t;
   endfunction

   function automatic logic [23:0] near(logic [23:0] base, int span);
      return 24'(base + $urandom_range(2 * span) - span);
   endfunction

   function automatic msa_req_type random_triangle();
      logic [23:0] c[9];
      int kind, span, i;
      kind = $urandom_range(3);
      span = 1 << $urandom_range(20);
      for (i = 0; i < 9; i++) begin
         case (kind)
            0: c[i] = 24'($urandom);
            1: c[i] = (i < 3) ? 24'($urandom) : near(c[i % 3], span);
            2: begin
               case ($urandom_range(4))
                  0: c[i] = 24'(COORD_MIN);
                  1: c[i] = 24'(COORD_MAX);
                  2: c[i] = '0;
                  3: c[i] = '1;
                  default: c[i] = 24'd1;
               endcase
            end
            default: c[i] = 24'($urandom_range(15) - 8);
         endcase
      end
      return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], 2'b00};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got, want);
      $display("%0t: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // entered and left at a falling edge
   task automatic send_triangle(input msa_req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_polygon(t);
      triangles_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_polygons.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_polygon();
      msa_req_type first_half, second_half;
      int shape;
      bit end_mesh;
      shape = $urandom_range(99);
      end_mesh = ($urandom_range(7) == 0);
      first_half = random_triangle();
      if (shape < 10) begin
         first_half.quad_first = 1'($urandom);
         first_half.last_in_mesh = 1'($urandom);
         send_triangle(first_half);
      end else if (shape < 55) begin
         first_half.last_in_mesh = end_mesh;
         send_triangle(first_half);
      end else begin
         second_half = random_triangle();
         if (shape < 80) begin
            second_half.a_x = first_half.a_x;
            second_half.a_y = first_half.a_y;
            second_half.a_z = first_half.a_z;
            second_half.b_x = first_half.c_x;
            second_half.b_y = first_half.c_y;
            second_half.b_z = first_half.c_z;
         end
         first_half.quad_first = 1'b1;
         first_half.last_in_mesh = ($urandom_range(7) == 0);
         second_half.quad_first = ($urandom_range(7) == 0);
         second_half.last_in_mesh = end_mesh;
         send_triangle(first_half);
         send_triangle(second_half);
      end
   endtask

   task automatic test_corner_extremes();
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MAX, COORD_MIN, 0, 0));
      send_triangle(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                             COORD_MAX, COORD_MIN, COORD_MIN, 0, 0));
      send_triangle(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MAX, COORD_MAX, 0, 0));
      send_triangle(make_tri(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                             COORD_MAX, COORD_MAX, COORD_MIN, 0, 1));
   endtask

   task automatic test_rounding();
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
      send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1, 0, 0));
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, 1));
   endtask

   task automatic test_quad_flags();
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, ONE, ONE, 0, 0, ONE, 0, 0, 0));
      // opposite windings cancel
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1, 0));
      send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0));
      // mesh end on the first half is dropped
      send_triangle(make_tri(0, 0, ONE, 3 * ONE, 0, 0, 0, 5, 7, 1, 1));
      send_triangle(make_tri(-ONE, 2, 0, ONE, -9, ONE, 0, ONE, 0, 0, 0));
      // quad_first on the second half is ignored
      send_triangle(make_tri(5, -ONE, 0, 0, ONE, 3, ONE, 0, -7, 1, 0));
      send_triangle(make_tri(1, 2, 3, -ONE, ONE, 0, ONE, ONE, ONE, 1, 1));
   endtask

   task automatic test_mesh_close();
      send_triangle(make_tri(0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 1));
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0));
      send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, -ONE, 0, 0, 1));
   endtask

   task automatic test_drain_pause();
      repeat (4) send_random_polygon();
      wait_for_results();
      @(negedge clock);
      repeat (4) send_random_polygon();
   endtask

   task automatic test_random_meshes();
      int idle_by_phase[4] = '{0, 84, 0, 15};
      int stall_by_phase[4] = '{0, 0, 84, 15};
      int phase, phase_end;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         phase_end = triangles_sent + 150;
         while (triangles_sent < phase_end) send_random_polygon();
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : result_check
      msa_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_polygons.size() == 0) begin
            report_mismatch("unexpected polygon, area", 64'(rsp_item.polygon_area), '0);
         end else begin
            want = pending_polygons.pop_front();
            if (rsp_item.polygon_area !== want.polygon_area)
               report_mismatch("polygon_area", 64'(rsp_item.polygon_area),
                               64'(want.polygon_area));
            if (rsp_item.total_area !== want.total_area)
               report_mismatch("total_area", rsp_item.total_area, want.total_area);
            if (rsp_item.mesh_done !== want.mesh_done)
               report_mismatch("mesh_done", 64'(rsp_item.mesh_done), 64'(want.mesh_done));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_corner_extremes();
      test_rounding();
      test_quad_flags();
      test_mesh_close();
      test_drain_pause();
      test_random_meshes();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_polygons.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
